>>> rtl/cfe_pkg.sv
// Shared types, constants and the DJB hash for the cuckoo filter engine.
// No dependencies; cfe_front, cfe_back and the top level import this package.
`default_nettype none

package cfe_pkg;

  // Hash seed and bit widths fixed by the item format
  localparam logic [15:0] DJB_SEED    = 16'd5381;
  localparam int          FP_W        = 16;
  localparam int          RELOC_W     = 4;
  localparam logic [3:0]  RELOC_RESET = 4'd8;

  // Opcode values of an input item
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Configuration register index, taken from paddr[2]
  localparam logic REG_MAX_RELOC = 1'b0;

  // Queue depth between the front and back parts and at the result side
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              opcode;
    logic [FP_W-1:0]   key;
    logic              victim_select;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [FP_W-1:0]    fingerprint;
    logic [RELOC_W-1:0] relocations_used;
  } out_item_t;

  // Classified command handed from the front part to the back part
  typedef struct packed {
    logic            lookup;
    logic            victim_select;
    logic [FP_W-1:0] fingerprint;
  } cmd_t;

  // 16-bit DJB hash of a 16-bit value, low byte first
  function automatic logic [15:0] djb16(input logic [15:0] v);
    logic [15:0] h;
    h = DJB_SEED;
    h = (h << 5) + h + {8'h00, v[7:0]};
    h = (h << 5) + h + {8'h00, v[15:8]};
    return h;
  endfunction

endpackage

`default_nettype wire

>>> rtl/cfe_fifo.sv
// Small synchronous queue used between the front and back parts and on the result side.
// Depends on nothing but its parameters.
`default_nettype none

module cfe_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_data = slot_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store payload, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cfe_front.sv
// Front part: accepts input items, hashes the key and classifies the operation.
// Depends on cfe_pkg.
`default_nettype none

module cfe_front (
  input  wire logic              push,
  output logic                   full,
  input  wire cfe_pkg::in_item_t in_item,
  input  wire logic              cmd_full,
  input  wire logic              clr_busy,
  output logic                   cmd_push,
  output cfe_pkg::cmd_t          cmd
);

  import cfe_pkg::*;

  // Hold off items while the command queue is full or the store is being cleared
  assign full     = cmd_full || clr_busy;
  assign cmd_push = push && !full;

  // Classify and fingerprint
  always_comb begin
    cmd.lookup        = (in_item.opcode == OP_LOOKUP);
    cmd.victim_select = in_item.victim_select;
    cmd.fingerprint   = djb16(in_item.key);
  end

endmodule

`default_nettype wire

>>> rtl/cfe_back.sv
// Back part: bucket store and the insert / lookup / relocation sequencer.
// Depends on cfe_pkg; the bucket store memory lives inside this module.
`default_nettype none

module cfe_back #(
  parameter int BUCKET_COUNT = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [3:0]         max_reloc,
  input  wire logic               cmd_valid,
  input  wire cfe_pkg::cmd_t      cmd,
  output logic                    cmd_pop,
  input  wire logic               res_full,
  output logic                    res_push,
  output cfe_pkg::out_item_t      res_item,
  output logic                    clr_busy
);

  import cfe_pkg::*;

  localparam int IW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam logic [IW-1:0] IDX_MASK = IW'(BUCKET_COUNT - 1);
  localparam logic [IW:0]   BC_EXT   = (IW + 1)'(BUCKET_COUNT);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RD2   = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_ALT   = 6'b010000,
    ST_PROBE = 6'b100000
  } state_t;

  // Alternate bucket: index XOR masked hash of the fingerprint, folded into range
  function automatic logic [IW-1:0] alt_idx(input logic [IW-1:0] idx,
                                            input logic [15:0]   fp);
    logic [15:0] h;
    logic [IW:0] x;
    h = djb16(fp);
    x = {1'b0, idx ^ (h[IW-1:0] & IDX_MASK)};
    if (x >= BC_EXT) begin
      x = x - BC_EXT;
    end
    return x[IW-1:0];
  endfunction

  state_t       state_r, state_nxt;
  logic [IW-1:0] clr_idx_r, clr_idx_nxt;
  logic         lookup_r, lookup_nxt;
  logic         vsel_r, vsel_nxt;
  logic [15:0]  fp_r, fp_nxt;
  logic [IW-1:0] i1_r, i1_nxt;
  logic [IW-1:0] i2_r, i2_nxt;
  logic [15:0]  b1_r, b1_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [15:0]  carry_r, carry_nxt;
  logic [3:0]   used_r, used_nxt;
  logic         res_ok;

  // Bucket store: one write and one registered read per cycle
  logic [15:0]   mem [BUCKET_COUNT];
  logic [15:0]   rd_data_r;
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign clr_busy = (state_r == ST_CLEAR);

  always_comb begin
    res_item.ok               = res_ok;
    res_item.fingerprint      = fp_r;
    res_item.relocations_used = used_r;
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    lookup_nxt  = lookup_r;
    vsel_nxt    = vsel_r;
    fp_nxt      = fp_r;
    i1_nxt      = i1_r;
    i2_nxt      = i2_r;
    b1_nxt      = b1_r;
    cur_nxt     = cur_r;
    carry_nxt   = carry_r;
    used_nxt    = used_r;
    mem_we      = 1'b0;
    mem_wa      = cur_r;
    mem_wd      = carry_r;
    mem_ra      = cur_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res_ok      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        // Sweep zeros through the store after reset
        mem_we      = 1'b1;
        mem_wa      = clr_idx_r;
        mem_wd      = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_MASK) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Take a command only when its result has a slot waiting
        if (cmd_valid && !res_full) begin
          cmd_pop    = 1'b1;
          lookup_nxt = cmd.lookup;
          vsel_nxt   = cmd.victim_select;
          fp_nxt     = cmd.fingerprint;
          i1_nxt     = cmd.fingerprint[IW-1:0] & IDX_MASK;
          mem_ra     = i1_nxt;
          used_nxt   = '0;
          state_nxt  = ST_RD2;
        end
      end
      ST_RD2: begin
        // First bucket arrives; fetch the second
        b1_nxt    = rd_data_r;
        i2_nxt    = alt_idx(i1_r, fp_r);
        mem_ra    = i2_nxt;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (lookup_r) begin
          res_push  = 1'b1;
          res_ok    = (b1_r == fp_r) || (rd_data_r == fp_r);
          state_nxt = ST_IDLE;
        end else if (b1_r == '0) begin
          mem_we    = 1'b1;
          mem_wa    = i1_r;
          mem_wd    = fp_r;
          res_push  = 1'b1;
          res_ok    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (rd_data_r == '0) begin
          mem_we    = 1'b1;
          mem_wa    = i2_r;
          mem_wd    = fp_r;
          res_push  = 1'b1;
          res_ok    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          // Evict the chosen victim and carry it
          cur_nxt   = vsel_r ? i1_r : i2_r;
          carry_nxt = vsel_r ? b1_r : rd_data_r;
          mem_we    = 1'b1;
          mem_wa    = cur_nxt;
          mem_wd    = fp_r;
          state_nxt = ST_ALT;
        end
      end
      ST_ALT: begin
        // Move to the carried entry's alternate bucket and read it
        cur_nxt   = alt_idx(cur_r, carry_r);
        mem_ra    = cur_nxt;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (rd_data_r == '0) begin
          mem_we    = 1'b1;
          res_push  = 1'b1;
          res_ok    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (used_r >= max_reloc) begin
          // Limit reached: drop the carried entry
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          mem_we    = 1'b1;
          used_nxt  = used_r + 1'b1;
          carry_nxt = rd_data_r;
          state_nxt = ST_ALT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    lookup_r <= lookup_nxt;
    vsel_r   <= vsel_nxt;
    fp_r     <= fp_nxt;
    i1_r     <= i1_nxt;
    i2_r     <= i2_nxt;
    b1_r     <= b1_nxt;
    cur_r    <= cur_nxt;
    carry_r  <= carry_nxt;
    used_r   <= used_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/cuckoo_filter_engine_core.sv
// Top level of the cuckoo filter engine: configuration register, queues and the two parts.
// Depends on cfe_pkg, cfe_fifo, cfe_front and cfe_back.
//
//   Port group        Direction  Handshake           Payload
//   input items       in         push / full         in_item (opcode, key, victim_select)
//   result items      out        pop / empty         out_item (ok, fingerprint, relocations_used)
//   configuration     in/out     psel/penable/pready paddr, pwdata, prdata (relocation limit)
//
// A lookup or an insert that finds an empty bucket runs the sequencer states IDLE, RD2 and
// EVAL; an insert that evicts then runs ALT and PROBE for each probe, as the bucket store has
// a single read and write port (a probe is an address step and then a read-and-write step).
// Items are worked one at a time; two commands and two results can wait in the queues.
// After reset, full stays high while the store is swept to zero.
// A stalled result side fills the result queue, then the command queue, then raises full.
`default_nettype none

module cuckoo_filter_engine_core #(
  parameter int BUCKET_COUNT = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire cfe_pkg::in_item_t  in_item,
  output logic                    empty,
  input  wire logic               pop,
  output cfe_pkg::out_item_t      out_item,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  import cfe_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(out_item_t);

  logic [3:0]     max_reloc_r, max_reloc_nxt;
  logic           cfg_wr;
  logic           cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t           cmd_in, cmd_out;
  logic [CMD_W-1:0] cmd_q_data;
  logic           res_push, res_full;
  out_item_t      res_item;
  logic [RES_W-1:0] res_q_data;
  logic           clr_busy;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_RELOC);
  assign max_reloc_nxt = cfg_wr ? pwdata[3:0] : max_reloc_r;
  assign prdata = (paddr[2] == REG_MAX_RELOC) ? {28'd0, max_reloc_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_reloc_r <= RELOC_RESET;
    end else begin
      max_reloc_r <= max_reloc_nxt;
    end
  end

  cfe_front u_front (
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .cmd_full (cmd_full),
    .clr_busy (clr_busy),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  cfe_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_q_data),
    .empty   (cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_q_data);

  cfe_back #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_reloc (max_reloc_r),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item),
    .clr_busy  (clr_busy)
  );

  cfe_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_q_data),
    .empty   (empty)
  );

  assign out_item = out_item_t'(res_q_data);

  // Checks on the sequencer and queues
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full result queue");

  a_cmd_avail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty command queue");

  a_reloc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_item.relocations_used <= max_reloc_r))
    else $error("relocation count beyond the configured limit");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> (empty && !res_push && !cmd_pop))
    else $error("item activity during the store clearing pass");

endmodule

`default_nettype wire
